/* src/utf8_byte_sanitizer_core_macros.svh */
// Assertion helpers shared by the sanitizer modules.
`ifndef UTF8_BYTE_SANITIZER_CORE_MACROS_SVH
`define UTF8_BYTE_SANITIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ubs_pkg.sv */
package ubs_pkg;

    // Default number of result groups buffered between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Most results that one input byte can cause.
    localparam int MAX_RUN = 4;

    // Byte classification constants.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;

    // One group of results caused by a single input byte.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [1:0]              last_idx;
        logic                    present;
        logic                    msg_end;
    } ubs_job_t;

endpackage

/* src/ubs_in_if.sv */
interface ubs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* src/ubs_out_if.sv */
interface ubs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_byte, output byte_present,
                    output run_end, output message_end, input ready);
    modport sink (input valid, input out_byte, input byte_present,
                  input run_end, input message_end, output ready);
endinterface

/* src/ubs_front.sv */
`include "utf8_byte_sanitizer_core_macros.svh"

module ubs_front (
    input  logic              clk,
    input  logic              rst_n,
    ubs_in_if.sink            in_stream,
    output logic              push_valid,
    output ubs_pkg::ubs_job_t push_job,
    input  logic              push_ready
);

    logic [1:0]       needed_reg, needed_next;
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic [2:0][7:0]  held_reg, held_next;
    logic [2:0]       emit_n;
    logic             accept;
    logic [7:0]       cur;
    logic             is_cont, is_print, is_lead2, is_lead3, is_lead4;
    logic             done;

    assign in_stream.ready = push_ready;
    assign accept = in_stream.valid && push_ready;
    assign cur = in_stream.in_byte;

    // Classify the incoming byte.
    assign is_cont  = (cur & ubs_pkg::MASK_CONT) == ubs_pkg::CODE_CONT;
    assign is_lead2 = (cur & ubs_pkg::MASK_LEAD2) == ubs_pkg::CODE_LEAD2;
    assign is_lead3 = (cur & ubs_pkg::MASK_LEAD3) == ubs_pkg::CODE_LEAD3;
    assign is_lead4 = (cur & ubs_pkg::MASK_LEAD4) == ubs_pkg::CODE_LEAD4;
    assign is_print = (cur >= ubs_pkg::CHAR_SPACE && cur <= ubs_pkg::CHAR_TILDE)
                   || cur == ubs_pkg::CHAR_TAB || cur == ubs_pkg::CHAR_LF
                   || cur == ubs_pkg::CHAR_CR;

    // Sequence tracking and assembly of the result group for this byte.
    always_comb
    begin
        needed_next   = needed_reg;
        held_cnt_next = held_cnt_reg;
        held_next     = held_reg;
        emit_n        = 3'd0;
        done          = 1'b0;
        push_job      = '0;

        if (needed_reg != 2'd0) begin
            if (is_cont) begin
                done = 1'b1;
                if (needed_reg == 2'd1) begin
                    // Sequence complete: held bytes first, then this one.
                    for (int j = 0; j < ubs_pkg::MAX_RUN - 1; j++) begin
                        if (2'(j) < held_cnt_reg) begin
                            push_job.bytes[j] = held_reg[j];
                        end
                    end
                    push_job.bytes[held_cnt_reg] = cur;
                    emit_n        = 3'(held_cnt_reg) + 3'd1;
                    needed_next   = 2'd0;
                    held_cnt_next = 2'd0;
                end else begin
                    if (held_cnt_reg != 2'd3) begin
                        held_next[held_cnt_reg] = cur;
                    end
                    held_cnt_next = held_cnt_reg + 2'd1;
                    needed_next   = needed_reg - 2'd1;
                end
            end else begin
                // Interrupted sequence: drop what is held.
                needed_next   = 2'd0;
                held_cnt_next = 2'd0;
            end
        end

        if (!done) begin
            if (is_print) begin
                push_job.bytes[0] = cur;
                emit_n            = 3'd1;
            end else if (is_lead2 || is_lead3 || is_lead4) begin
                held_next[0]  = cur;
                held_cnt_next = 2'd1;
                if (is_lead2) begin
                    needed_next = 2'd1;
                end else if (is_lead3) begin
                    needed_next = 2'd2;
                end else begin
                    needed_next = 2'd3;
                end
            end
        end

        if (in_stream.in_last) begin
            needed_next   = 2'd0;
            held_cnt_next = 2'd0;
        end

        push_job.present  = emit_n != 3'd0;
        push_job.last_idx = (emit_n == 3'd0) ? 2'd0 : 2'(emit_n - 3'd1);
        push_job.msg_end  = in_stream.in_last;
    end

    assign push_valid = in_stream.valid && (emit_n != 3'd0 || in_stream.in_last);

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            needed_reg   <= 2'd0;
            held_cnt_reg <= 2'd0;
        end else if (accept) begin
            needed_reg   <= needed_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    // Held bytes carry no reset; only written entries are read.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

    `UBS_ASSERT_NOW(a_open_matches_held, clk, rst_n, 1'b1,
        (needed_reg == 2'd0) == (held_cnt_reg == 2'd0),
        "open sequence and held byte count disagree")
    `UBS_ASSERT_NOW(a_held_bound, clk, rst_n, 1'b1,
        3'(needed_reg) + 3'(held_cnt_reg) <= 3'd4,
        "held and missing byte counts exceed a 4-byte form")
    `UBS_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_stream.in_last,
        needed_reg == 2'd0 && held_cnt_reg == 2'd0,
        "sequence state not cleared at message end")

endmodule

/* src/ubs_queue.sv */
`include "utf8_byte_sanitizer_core_macros.svh"

module ubs_queue #(
    parameter int DEPTH = ubs_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  ubs_pkg::ubs_job_t push_job,
    output logic              push_ready,
    output logic              head_valid,
    output ubs_pkg::ubs_job_t head_job,
    input  logic              pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ubs_pkg::ubs_job_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          take;

    assign push_ready = count_reg != CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign take       = pop && head_valid;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !take) begin
                count_reg <= count_reg + 1'b1;
            end else if (take && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `UBS_ASSERT_NEXT(a_pop_drains, clk, rst_n, take && !push,
        count_reg == $past(count_reg) - 1'b1,
        "queue count did not drop on a pop")

endmodule

/* src/ubs_back.sv */
`include "utf8_byte_sanitizer_core_macros.svh"

module ubs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ubs_pkg::ubs_job_t head_job,
    output logic              pop,
    ubs_out_if.source         out_stream
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       present_reg, run_end_reg, msg_end_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    assign load    = !out_valid_reg || out_stream.ready;
    assign at_last = idx_reg == head_job.last_idx;
    assign pop     = load && head_valid && at_last;
    assign idx_next = at_last ? 2'd0 : idx_reg + 2'd1;

    // Output transaction and position within the current group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            out_valid_reg <= head_valid;
            if (head_valid) begin
                idx_reg <= idx_next;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load && head_valid) begin
            out_byte_reg <= head_job.bytes[idx_reg];
            present_reg  <= head_job.present;
            run_end_reg  <= at_last;
            msg_end_reg  <= at_last && head_job.msg_end;
        end
    end

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.out_byte     = out_byte_reg;
    assign out_stream.byte_present = present_reg;
    assign out_stream.run_end      = run_end_reg;
    assign out_stream.message_end  = msg_end_reg;

    `UBS_ASSERT_NOW(a_idx_in_group, clk, rst_n, head_valid,
        idx_reg <= head_job.last_idx,
        "result index ran past the end of its group")
    `UBS_ASSERT_NOW(a_end_marks, clk, rst_n, out_valid_reg && msg_end_reg,
        run_end_reg,
        "message end raised without run end")

endmodule

/* src/utf8_byte_sanitizer_core.sv */
// UTF-8 sanitizer for a message-framed byte stream. Printable ASCII, tab, LF
// and CR pass; other control bytes, stray continuation bytes and F8-FF are
// dropped; a complete 2-, 3- or 4-byte sequence leaves as one run of bytes on
// the transaction that completes it, and an interrupted or unfinished one is
// dropped. Each input byte yields 0 to 4 output transactions; run_end marks the
// last of them and message_end the last of the message (a message whose final
// byte keeps nothing still ends with one transaction that has byte_present 0).
// Input is taken at one byte per clock. The output side drains one
// transaction per clock from its register while the receiver is ready, so a
// finished multi-byte run holds the back end until all its bytes have left;
// the QUEUE_DEPTH-entry queue between the classifier and the output stage
// absorbs that burst, and input stalls only when it is full. Each result is
// registered in the queue and then in the output register.
module utf8_byte_sanitizer_core #(
    parameter int QUEUE_DEPTH = ubs_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ubs_in_if.sink    in_stream,
    ubs_out_if.source out_stream
);

    logic              push_valid;
    logic              push_ready;
    ubs_pkg::ubs_job_t push_job;
    logic              head_valid;
    ubs_pkg::ubs_job_t head_job;
    logic              pop;

    // Classifier and sequence tracker.
    ubs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // Burst buffer of result groups.
    ubs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Serializer and output register.
    ubs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule

/* dv/tb_top.sv */
module tb_top;

    // One output transaction of the sanitizer.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_end;
        logic       msg_end;
    } san_result_t;

    // Tracks the UTF-8 filter state and holds the output transactions still owed.
    class sanitizer_scoreboard;
        bit [1:0]    need_cnt;
        bit [1:0]    held_cnt;
        bit [7:0]    held [3];
        san_result_t owed_q[$];
        int          errors;

        function new();
            need_cnt = 0;
            held_cnt = 0;
            errors   = 0;
        endfunction

        function san_result_t kept(input logic [7:0] data, input logic present);
            san_result_t r;
            r.data    = data;
            r.present = present;
            r.run_end = 1'b0;
            r.msg_end = 1'b0;
            return r;
        endfunction

        function void hold_byte(input logic [7:0] data);
            if (held_cnt < 3) begin
                held[held_cnt] = data;
                held_cnt++;
            end
        endfunction

        // Work out the run of output transactions caused by one accepted byte.
        function void note_input(input logic [7:0] data, input logic last);
            san_result_t run[$];
            bit          taken;
            int          i;
            taken = 0;

            // An open sequence either takes a continuation byte or is abandoned.
            if (need_cnt != 0) begin
                if ((data & ubs_pkg::MASK_CONT) == ubs_pkg::CODE_CONT) begin
                    taken = 1;
                    if (need_cnt == 1) begin
                        for (i = 0; i < held_cnt; i++)
                            run.push_back(kept(held[i], 1'b1));
                        run.push_back(kept(data, 1'b1));
                        need_cnt = 0;
                        held_cnt = 0;
                    end
                    else begin
                        hold_byte(data);
                        need_cnt--;
                    end
                end
                else begin
                    need_cnt = 0;
                    held_cnt = 0;
                end
            end

            // Fresh classification of the byte.
            if (!taken) begin
                if ((data >= ubs_pkg::CHAR_SPACE && data <= ubs_pkg::CHAR_TILDE) ||
                    data == ubs_pkg::CHAR_TAB || data == ubs_pkg::CHAR_LF ||
                    data == ubs_pkg::CHAR_CR) begin
                    run.push_back(kept(data, 1'b1));
                end
                else if ((data & ubs_pkg::MASK_LEAD2) == ubs_pkg::CODE_LEAD2) begin
                    hold_byte(data);
                    need_cnt = 1;
                end
                else if ((data & ubs_pkg::MASK_LEAD3) == ubs_pkg::CODE_LEAD3) begin
                    hold_byte(data);
                    need_cnt = 2;
                end
                else if ((data & ubs_pkg::MASK_LEAD4) == ubs_pkg::CODE_LEAD4) begin
                    hold_byte(data);
                    need_cnt = 3;
                end
            end

            // The end of a message drops any open sequence and is always signalled.
            if (last) begin
                need_cnt = 0;
                held_cnt = 0;
                if (run.size() == 0)
                    run.push_back(kept(8'h00, 1'b0));
                run[run.size()-1].msg_end = 1'b1;
            end
            if (run.size() > 0)
                run[run.size()-1].run_end = 1'b1;
            for (i = 0; i < run.size(); i++)
                owed_q.push_back(run[i]);
        endfunction

        // Compare one accepted output transaction with the oldest one owed.
        function void check_result(input san_result_t got);
            san_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected output transaction %h", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.data !== want.data) begin
                $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
                errors++;
            end
            if (got.present !== want.present) begin
                $display("%0t: byte_present expected %b actual %b", $time,
                         want.present, got.present);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %b actual %b", $time,
                         want.run_end, got.run_end);
                errors++;
            end
            if (got.msg_end !== want.msg_end) begin
                $display("%0t: message_end expected %b actual %b", $time,
                         want.msg_end, got.msg_end);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    ubs_in_if  in_if();
    ubs_out_if out_if();

    utf8_byte_sanitizer_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    sanitizer_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int quiet_cycles = 0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver stalls at random on each falling edge.
    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_if.valid && out_if.ready) begin
                sb.check_result({out_if.out_byte, out_if.byte_present,
                                 out_if.run_end, out_if.message_end});
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_input(in_if.in_byte, in_if.in_last);
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offer one byte, with a random idle gap first, and wait for its handshake.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge clk);
            in_if.valid <= 1'b0;
        end
        @(negedge clk);
        in_if.valid   <= 1'b1;
        in_if.in_byte <= data;
        in_if.in_last <= last;
        do
            @(posedge clk);
        while (!in_if.ready);
        bytes_sent++;
    endtask

    // Append a lead byte of the given length and some of its continuation bytes.
    task automatic add_sequence(inout logic [7:0] msg[$], input int len, input int conts);
        int k;
        case (len)
            2: msg.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            3: msg.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            default: msg.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        for (k = 0; k < conts; k++)
            msg.push_back(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // Send one random message, mostly well-formed text with some noise.
    task automatic send_message();
        logic [7:0] msg[$];
        int         tokens;
        int         pick;
        int         len;
        int         t;
        int         i;
        tokens = $urandom_range(1, 6);
        for (t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(2, 4);
            if (pick < 40)
                add_sequence(msg, len, len - 1);
            else if (pick < 60) begin
                case ($urandom_range(0, 5))
                    0: msg.push_back(ubs_pkg::CHAR_TAB);
                    1: msg.push_back(ubs_pkg::CHAR_LF);
                    2: msg.push_back(ubs_pkg::CHAR_CR);
                    default: msg.push_back(8'($urandom_range(32, 126)));
                endcase
            end
            else if (pick < 75)
                add_sequence(msg, len, $urandom_range(0, len - 2));
            else
                msg.push_back(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Main sequence: reset, directed cases, random phases, drain.
    initial
    begin
        int phase;
        int target;
        sb = new();
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Printable extremes, the three kept controls, and dropped bytes.
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(ubs_pkg::CHAR_TAB, 1'b0);
        send_byte(ubs_pkg::CHAR_LF, 1'b0);
        send_byte(ubs_pkg::CHAR_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        // Stray continuation byte.
        send_byte(8'h80, 1'b0);
        // Complete 2-, 3- and 4-byte forms, the last one closing the message.
        send_byte(8'hC0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Interrupted sequence: the interrupting byte starts a new one.
        send_byte(8'hE2, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        // Sequence still open at the end of the message.
        send_byte(8'hC3, 1'b1);
        // Message ending on a dropped byte.
        send_byte(8'h1F, 1'b1);

        // Random messages under each idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            target = bytes_sent + 48;
            while (bytes_sent < target)
                send_message();
        end
        @(negedge clk);
        in_if.valid <= 1'b0;
        stall_pct = 0;

        // Wait for every owed transaction, then a further drain period.
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.owed_q.size() != 0)
            $display("%0t: %0d output transactions never arrived", $time, sb.owed_q.size());
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
